[rtl/lkct_pkg.sv]
// shared types and constants for the lfu keyed cache table
`default_nettype none

package lkct_pkg;

    // widths fixed by the word format
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned KEY_W    = 64;

    // request codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_MISS    = 3'd0,
        ST_HIT     = 3'd1,
        ST_DUP     = 3'd2,
        ST_ADD     = 3'd3,
        ST_REPLACE = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // flags from the shared compare unit
    typedef struct packed {
        logic eq;   // stored key equals request key
        logic lt;   // stored count below current minimum
    } t_cmp_res;

endpackage

`default_nettype wire

[rtl/lkct_cmp.sv]
// shared compare unit: key match and use count minimum test
`default_nettype none

module lkct_cmp #(
    parameter int unsigned KEY_BITS   = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic [KEY_BITS-1:0]   i_key_a,
    input  wire logic [KEY_BITS-1:0]   i_key_b,
    input  wire logic [COUNT_BITS-1:0] i_cnt_a,
    input  wire logic [COUNT_BITS-1:0] i_cnt_b,
    output lkct_pkg::t_cmp_res         o_res
);

    // one key equality and one count less-than per cycle
    always_comb begin
        o_res.eq = (i_key_a == i_key_b);
        o_res.lt = (i_cnt_a < i_cnt_b);
    end

endmodule

`default_nettype wire

[rtl/lkct_store.sv]
// entry store: keys, handles and use counts, one write and one read port
`default_nettype none

module lkct_store #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_rd_addr,
    output logic      [KEY_BITS-1:0]          o_rd_key,
    output logic      [lkct_pkg::HANDLE_W-1:0] o_rd_handle,
    output logic      [COUNT_BITS-1:0]        o_rd_cnt,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_wr_addr,
    input  wire logic [KEY_BITS-1:0]          i_wr_key,
    input  wire logic [lkct_pkg::HANDLE_W-1:0] i_wr_handle,
    input  wire logic [COUNT_BITS-1:0]        i_wr_cnt
);

    logic [KEY_BITS-1:0]           mem_key    [ENTRIES];
    logic [lkct_pkg::HANDLE_W-1:0] mem_handle [ENTRIES];
    logic [COUNT_BITS-1:0]         mem_cnt    [ENTRIES];

    // whole entry written at once
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_key[i_wr_addr]    <= i_wr_key;
            mem_handle[i_wr_addr] <= i_wr_handle;
            mem_cnt[i_wr_addr]    <= i_wr_cnt;
        end
    end

    // registered read, one entry per cycle
    always_ff @(posedge i_clk) begin
        o_rd_key    <= mem_key[i_rd_addr];
        o_rd_handle <= mem_handle[i_rd_addr];
        o_rd_cnt    <= mem_cnt[i_rd_addr];
    end

endmodule

`default_nettype wire

[rtl/lkct_ctrl.sv]
// sequencer: entry scan, hit and victim tracking, update and result register
`default_nettype none

module lkct_ctrl #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request side
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_opcode,
    input  wire logic [lkct_pkg::KEY_W-1:0]     i_lookup_key,
    input  wire logic [lkct_pkg::HANDLE_W-1:0]  i_data_handle,
    // result side
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [lkct_pkg::STATUS_W-1:0]  o_status,
    output logic      [lkct_pkg::HANDLE_W-1:0]  o_data_out,
    output logic      [lkct_pkg::SLOT_W-1:0]    o_slot_index,
    // store ports
    output logic      [$clog2(ENTRIES)-1:0]     o_rd_addr,
    input  wire logic [KEY_BITS-1:0]            i_rd_key,
    input  wire logic [lkct_pkg::HANDLE_W-1:0]  i_rd_handle,
    input  wire logic [COUNT_BITS-1:0]          i_rd_cnt,
    output logic                                o_wr_en,
    output logic      [$clog2(ENTRIES)-1:0]     o_wr_addr,
    output logic      [KEY_BITS-1:0]            o_wr_key,
    output logic      [lkct_pkg::HANDLE_W-1:0]  o_wr_handle,
    output logic      [COUNT_BITS-1:0]          o_wr_cnt
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W:0] FULL_FILL = (IDX_W+1)'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    lkct_pkg::t_state   r_state, n_state;
    lkct_pkg::t_cmp_res cmp;

    // latched request
    logic                          r_op;
    logic [KEY_BITS-1:0]           r_key;
    logic [lkct_pkg::HANDLE_W-1:0] r_handle;

    // table occupancy and scan pointers
    logic [IDX_W:0]   r_fill, n_fill;
    logic [IDX_W:0]   r_idx;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    logic             issue;
    logic             match;

    // hit and victim candidates
    logic                          r_found;
    logic [IDX_W-1:0]              r_hit_idx;
    logic [lkct_pkg::HANDLE_W-1:0] r_hit_handle;
    logic [COUNT_BITS-1:0]         r_hit_cnt;
    logic [IDX_W-1:0]              r_min_idx;
    logic [COUNT_BITS-1:0]         r_min_cnt;
    logic [lkct_pkg::HANDLE_W-1:0] r_min_handle;

    // result register
    logic                          r_ovalid;
    lkct_pkg::t_status             r_status, n_status;
    logic [lkct_pkg::HANDLE_W-1:0] r_data, n_data;
    logic [lkct_pkg::SLOT_W-1:0]   r_slot;
    logic [IDX_W+lkct_pkg::SLOT_W-1:0] n_slot_ext;
    logic [IDX_W-1:0]              n_slot_idx;
    logic                          load;
    logic                          accept;
    logic                          table_full;

    // shared compare unit
    lkct_cmp #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_cmp (
        .i_key_a (i_rd_key),
        .i_key_b (r_key),
        .i_cnt_a (i_rd_cnt),
        .i_cnt_b (r_min_cnt),
        .o_res   (cmp)
    );

    assign accept     = i_valid && o_ready;
    assign match      = r_pend && cmp.eq;
    assign table_full = (r_fill == FULL_FILL);
    assign issue      = (r_state == lkct_pkg::S_SCAN) && (r_idx < r_fill) && !r_found
                        && !match;
    assign o_rd_addr  = r_idx[IDX_W-1:0];

    // next state, update write and result
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_status   = lkct_pkg::ST_MISS;
        n_data     = '0;
        n_slot_idx = '0;
        load       = 1'b0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_hit_idx;
        o_wr_key   = r_key;
        o_wr_handle = r_handle;
        o_wr_cnt   = CNT_ONE;
        unique case (r_state)
            lkct_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = lkct_pkg::S_SCAN;
                end
            end
            lkct_pkg::S_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = lkct_pkg::S_DONE;
                end
            end
            lkct_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    load    = 1'b1;
                    n_state = lkct_pkg::S_IDLE;
                    if (r_op == lkct_pkg::OP_LOOKUP) begin
                        if (r_found) begin
                            n_status    = lkct_pkg::ST_HIT;
                            n_data      = r_hit_handle;
                            n_slot_idx  = r_hit_idx;
                            o_wr_en     = 1'b1;
                            o_wr_handle = r_hit_handle;
                            o_wr_cnt    = (r_hit_cnt == CNT_MAX) ? r_hit_cnt
                                                                 : r_hit_cnt + CNT_ONE;
                        end
                    end else if (r_found) begin
                        n_status   = lkct_pkg::ST_DUP;
                        n_slot_idx = r_hit_idx;
                    end else if (!table_full) begin
                        n_status   = lkct_pkg::ST_ADD;
                        n_slot_idx = r_fill[IDX_W-1:0];
                        o_wr_en    = 1'b1;
                        o_wr_addr  = r_fill[IDX_W-1:0];
                        n_fill     = r_fill + (IDX_W+1)'(1);
                    end else begin
                        n_status   = lkct_pkg::ST_REPLACE;
                        n_data     = r_min_handle;
                        n_slot_idx = r_min_idx;
                        o_wr_en    = 1'b1;
                        o_wr_addr  = r_min_idx;
                    end
                end
            end
            default: n_state = lkct_pkg::S_IDLE;
        endcase
        n_slot_ext = {{lkct_pkg::SLOT_W{1'b0}}, n_slot_idx};
    end

    // state, occupancy and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lkct_pkg::S_IDLE;
            r_fill   <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= issue;
            if (accept) begin
                r_found <= 1'b0;
            end else if (match) begin
                r_found <= 1'b1;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request word, scan pointer and candidates
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_opcode;
            r_key    <= i_lookup_key[KEY_BITS-1:0];
            r_handle <= i_data_handle;
            r_idx    <= '0;
        end else if (issue) begin
            r_idx <= r_idx + (IDX_W+1)'(1);
        end
        r_pend_idx <= r_idx[IDX_W-1:0];
        if (match) begin
            r_hit_idx    <= r_pend_idx;
            r_hit_handle <= i_rd_handle;
            r_hit_cnt    <= i_rd_cnt;
        end
        // lowest index wins a tie: only a strictly smaller count moves the victim
        if (r_pend && ((r_pend_idx == '0) || cmp.lt)) begin
            r_min_idx    <= r_pend_idx;
            r_min_cnt    <= i_rd_cnt;
            r_min_handle <= i_rd_handle;
        end
        if (load) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_slot   <= n_slot_ext[lkct_pkg::SLOT_W-1:0];
        end
    end

    assign o_ready      = (r_state == lkct_pkg::S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_data_out   = r_data;
    assign o_slot_index = r_slot;

    // occupancy never passes the table size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill count above table size");

    // reads only come back while scanning
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == lkct_pkg::S_SCAN))
        else $error("read data pending outside scan");

    // occupancy moves only by one, and only on a completed request
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |->
            (r_fill == $past(r_fill) + (IDX_W+1)'(1)) && $past(load))
        else $error("fill count jumped");

    // an accepted word starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == lkct_pkg::S_SCAN))
        else $error("accepted word did not start a scan");

    // the store is written only when a result is loaded
    a_wr_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> load)
        else $error("store written without a result");

endmodule

`default_nettype wire

[rtl/lfu_keyed_cache_table.sv]
// top level of the lfu keyed cache table
`default_nettype none

// Fully associative table of ENTRIES keyed entries with least-frequently-used
// replacement. One request word (lookup or insert) is taken at a time: the
// sequencer reads the filled entries one per cycle from the entry store and
// runs each through a shared key/count compare unit, stopping early on a key
// match. After the scan the sequencer loads the result and writes the store
// update in its done state, once the output register is free, and then goes
// back to idle to take the next word. The result sits in an output register,
// so the next word can be taken while the previous result waits. Keys use
// only the low KEY_BITS bits; use counts saturate at all ones.
module lfu_keyed_cache_table #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_opcode,
    input  wire logic [lkct_pkg::KEY_W-1:0]    i_lookup_key,
    input  wire logic [lkct_pkg::HANDLE_W-1:0] i_data_handle,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [lkct_pkg::STATUS_W-1:0] o_status,
    output logic      [lkct_pkg::HANDLE_W-1:0] o_data_out,
    output logic      [lkct_pkg::SLOT_W-1:0]   o_slot_index
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    logic [IDX_W-1:0]              rd_addr;
    logic [KEY_BITS-1:0]           rd_key;
    logic [lkct_pkg::HANDLE_W-1:0] rd_handle;
    logic [COUNT_BITS-1:0]         rd_cnt;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [KEY_BITS-1:0]           wr_key;
    logic [lkct_pkg::HANDLE_W-1:0] wr_handle;
    logic [COUNT_BITS-1:0]         wr_cnt;

    // entry store
    lkct_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .o_rd_key    (rd_key),
        .o_rd_handle (rd_handle),
        .o_rd_cnt    (rd_cnt),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_key    (wr_key),
        .i_wr_handle (wr_handle),
        .i_wr_cnt    (wr_cnt)
    );

    // scan sequencer
    lkct_ctrl #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_lookup_key  (i_lookup_key),
        .i_data_handle (i_data_handle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_slot_index  (o_slot_index),
        .o_rd_addr     (rd_addr),
        .i_rd_key      (rd_key),
        .i_rd_handle   (rd_handle),
        .i_rd_cnt      (rd_cnt),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_key      (wr_key),
        .o_wr_handle   (wr_handle),
        .o_wr_cnt      (wr_cnt)
    );

endmodule

`default_nettype wire

[bench/lkct_reply_checker.sv]
// reply checker for the lfu keyed cache table: predicts every reply word and compares
module lkct_reply_checker #(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic [lkct_pkg::KEY_W-1:0]    i_lookup_key,
    input  wire logic [lkct_pkg::HANDLE_W-1:0] i_data_handle,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [lkct_pkg::STATUS_W-1:0] i_status,
    input  wire logic [lkct_pkg::HANDLE_W-1:0] i_data_out,
    input  wire logic [lkct_pkg::SLOT_W-1:0]   i_slot_index,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam logic [lkct_pkg::KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= lkct_pkg::KEY_W) ? {lkct_pkg::KEY_W{1'b1}}
                                      : ((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef struct {
        lkct_pkg::t_status                 status;
        logic [lkct_pkg::HANDLE_W-1:0]     handle;
        logic [lkct_pkg::SLOT_W-1:0]       slot;
    } t_reply;

    // shadow copy of the table
    logic [lkct_pkg::KEY_W-1:0]    stored_keys    [ENTRIES];
    logic [lkct_pkg::HANDLE_W-1:0] stored_handles [ENTRIES];
    logic [COUNT_BITS-1:0]         use_counts     [ENTRIES];
    int                            filled;

    // replies owed by the block, oldest first
    t_reply replies_due [$];

    // applies one request word to the shadow table and returns its reply
    function automatic t_reply cache_access(input logic op,
                                            input logic [lkct_pkg::KEY_W-1:0] raw_key,
                                            input logic [lkct_pkg::HANDLE_W-1:0] handle);
        t_reply                     r;
        logic [lkct_pkg::KEY_W-1:0] key;
        int                         found;
        int                         victim;
        key      = raw_key & KEY_MASK;
        found    = -1;
        victim   = 0;
        r.status = lkct_pkg::ST_MISS;
        r.handle = '0;
        r.slot   = '0;
        // lowest matching filled entry
        for (int i = 0; i < filled; i++) begin
            if (found < 0 && stored_keys[i] == key) begin
                found = i;
            end
        end
        if (op == lkct_pkg::OP_LOOKUP) begin
            if (found >= 0) begin
                if (use_counts[found] != COUNT_TOP) begin
                    use_counts[found] = use_counts[found] + COUNT_ONE;
                end
                r.status = lkct_pkg::ST_HIT;
                r.handle = stored_handles[found];
                r.slot   = found[lkct_pkg::SLOT_W-1:0];
            end
        end else if (found >= 0) begin
            r.status = lkct_pkg::ST_DUP;
            r.slot   = found[lkct_pkg::SLOT_W-1:0];
        end else begin
            if (filled < ENTRIES) begin
                victim   = filled;
                filled   = filled + 1;
                r.status = lkct_pkg::ST_ADD;
            end else begin
                // smallest count wins, lowest index on a tie
                for (int i = 1; i < ENTRIES; i++) begin
                    if (use_counts[i] < use_counts[victim]) begin
                        victim = i;
                    end
                end
                r.status = lkct_pkg::ST_REPLACE;
                r.handle = stored_handles[victim];
            end
            stored_keys[victim]    = key;
            stored_handles[victim] = handle;
            use_counts[victim]     = COUNT_ONE;
            r.slot                 = victim[lkct_pkg::SLOT_W-1:0];
        end
        return r;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what);
        o_fail_count = o_fail_count + 1;
        $display("[%0t] reply mismatch: %s", $time, what);
    endtask

    // watch both channels; replies are taken before requests of the same edge
    always @(posedge i_clk) begin : watch_words
        t_reply want;
        if (!i_rst_n) begin
            filled = 0;
            replies_due.delete();
        end else begin
            if ((i_out_valid & i_out_ready) === 1'b1) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, status %0d", i_status));
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                    if (i_data_out !== want.handle) begin
                        report_mismatch($sformatf("data_out %h, expected %h",
                                                  i_data_out, want.handle));
                    end
                    if (i_slot_index !== want.slot) begin
                        report_mismatch($sformatf("slot_index %0d, expected %0d",
                                                  i_slot_index, want.slot));
                    end
                end
            end
            if ((i_in_valid & i_in_ready) === 1'b1) begin
                replies_due.push_back(cache_access(i_opcode, i_lookup_key, i_data_handle));
            end
        end
        o_pending = replies_due.size();
    end

endmodule

[bench/lfu_keyed_cache_table_tb.sv]
// testbench top for the lfu keyed cache table: stimulus, handshake pacing and verdict
module lfu_keyed_cache_table_tb;

    localparam int unsigned ENTRIES    = 16;
    localparam int unsigned KEY_BITS   = 64;
    localparam int unsigned COUNT_BITS = 16;
    localparam int          RAND_WORDS = 360;
    localparam int          POOL_SIZE  = 24;
    // repeated hits on slot 0 during the stretch with no idling
    localparam int          STEADY_HITS = 20;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_opcode;
    logic [lkct_pkg::KEY_W-1:0]    i_lookup_key;
    logic [lkct_pkg::HANDLE_W-1:0] i_data_handle;
    logic                          o_valid;
    logic                          i_ready;
    logic [lkct_pkg::STATUS_W-1:0] o_status;
    logic [lkct_pkg::HANDLE_W-1:0] o_data_out;
    logic [lkct_pkg::SLOT_W-1:0]   o_slot_index;

    int                         fail_count;
    int                         pending;
    logic                       rx_steady;
    int                         hold_ticket;
    bit                         tx_steady;
    logic [lkct_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    lfu_keyed_cache_table #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_lookup_key  (i_lookup_key),
        .i_data_handle (i_data_handle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_slot_index  (o_slot_index)
    );

    lkct_reply_checker #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_opcode      (i_opcode),
        .i_lookup_key  (i_lookup_key),
        .i_data_handle (i_data_handle),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_status      (o_status),
        .i_data_out    (o_data_out),
        .i_slot_index  (o_slot_index),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        #2_400_000;
        $display("lfu_keyed_cache_table_tb NOT OK");
        $finish;
    end

    // reply side: random stalls, steady stretches and long hold-offs on request
    initial begin : reply_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // offer one request word and hold it until taken
    task automatic send_word(input logic op, input logic [lkct_pkg::KEY_W-1:0] key,
                             input logic [lkct_pkg::HANDLE_W-1:0] handle);
        while (!tx_steady && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_lookup_key  <= key;
        i_data_handle <= handle;
        @(posedge i_clk);
        while (o_ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    // stop offering until every owed reply has come back
    task automatic drain_replies;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // request side and verdict
    initial begin : request_side
        logic                       op;
        logic [lkct_pkg::KEY_W-1:0] key;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_opcode      <= lkct_pkg::OP_LOOKUP;
        i_lookup_key  <= '0;
        i_data_handle <= '0;
        rx_steady     <= 1'b0;
        hold_ticket   <= 0;
        tx_steady     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lookup on an empty table, then the extreme keys and handles
        send_word(lkct_pkg::OP_LOOKUP, '0, '1);
        send_word(lkct_pkg::OP_INSERT, '0, '0);
        send_word(lkct_pkg::OP_INSERT, '1, '1);
        send_word(lkct_pkg::OP_LOOKUP, '1, '0);
        send_word(lkct_pkg::OP_LOOKUP, '0, $urandom);
        // duplicate insert must leave the stored handle alone
        send_word(lkct_pkg::OP_INSERT, '0, 32'hDEAD_BEEF);
        send_word(lkct_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, $urandom);
        send_word(lkct_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000);
        // fill the remaining slots
        for (int b = 0; b < ENTRIES - 3; b++) begin
            send_word(lkct_pkg::OP_INSERT, 64'd1 << b, $urandom);
        end
        // full table: counts tie at one from slot 2 up, lowest index goes
        send_word(lkct_pkg::OP_INSERT, 64'h5555_5555_5555_5555, $urandom);
        send_word(lkct_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, $urandom);
        send_word(lkct_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, $urandom);

        // long stretch with no idling: repeated hits on slot 0, then a replace
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        repeat (STEADY_HITS) send_word(lkct_pkg::OP_LOOKUP, '0, $urandom);
        send_word(lkct_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, $urandom);
        repeat (3) send_word(lkct_pkg::OP_LOOKUP, '0, $urandom);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        drain_replies();

        // small key pool so hits, duplicates and replacements stay common
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        for (int n = 0; n < RAND_WORDS; n++) begin
            // reply side holds off while words keep coming
            if (n == 120) begin
                hold_ticket <= hold_ticket + 1;
            end
            if (n == 200) begin
                tx_steady = 1'b1;
                rx_steady <= 1'b1;
            end
            if (n == 260) begin
                tx_steady = 1'b0;
                rx_steady <= 1'b0;
            end
            if (n == 300) begin
                drain_replies();
            end
            op = ($urandom_range(0, 99) < 40) ? lkct_pkg::OP_INSERT : lkct_pkg::OP_LOOKUP;
            if ($urandom_range(0, 99) < 12) begin
                key = {$urandom, $urandom};
            end else begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_word(op, key, $urandom);
        end

        drain_replies();
        // a late stray word would show up within a full scan time
        repeat (ENTRIES + 8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("lfu_keyed_cache_table_tb OK");
        end else begin
            $display("lfu_keyed_cache_table_tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lkct_pkg.sv
rtl/lkct_cmp.sv
rtl/lkct_store.sv
rtl/lkct_ctrl.sv
rtl/lfu_keyed_cache_table.sv
bench/lkct_reply_checker.sv
bench/lfu_keyed_cache_table_tb.sv
